// ===== src/ple_pkg.sv =====
package ple_pkg;

	// command codes of the input word
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_SEARCH = 2'd2;
	localparam logic [1:0] FN_UPDATE = 2'd3;

	// status codes of the result word
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	localparam int DATA_W = 32;
	localparam int GRP_N  = 16;
	localparam int GRP_IW = 4;

	// -1 in the 7-bit index field
	localparam logic [6:0] IDX_NONE = 7'h7F;

	// broadcast to every cell of the list
	typedef struct packed {
		logic              ins;      // shift up above position, write at position
		logic              rem;      // shift down from position on
		logic              upd;      // overwrite at position
		logic              mark_pos; // flag the cell at position
		logic              mark_val; // flag live cells equal to data
		logic [DATA_W-1:0] data;
	} cell_cmd_t;

	// one slot of the group scan chain
	typedef struct packed {
		logic              any;
		logic [GRP_IW-1:0] idx;
		logic [DATA_W-1:0] val;
	} grp_t;

endpackage

// ===== src/ple_cell.sv =====
module ple_cell #(
	parameter int PW  = 7,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ple_pkg::cell_cmd_t       cmd,
	input  logic [PW-1:0]            pos,
	input  logic [PW-1:0]            count,
	input  logic [ple_pkg::DATA_W-1:0] left,
	input  logic [ple_pkg::DATA_W-1:0] right,
	output logic [ple_pkg::DATA_W-1:0] value,
	output logic                     hit
);
	import ple_pkg::*;

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [DATA_W-1:0] val_q;
	logic              hit_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (MY_IDX == pos);
	assign above_pos = (MY_IDX > pos);

	// shift, write or hold the entry
	always_ff @(posedge clk) begin
		if (cmd.ins && above_pos) begin
			val_q <= left;
		end else if ((cmd.ins || cmd.upd) && at_pos) begin
			val_q <= cmd.data;
		end else if (cmd.rem && (at_pos || above_pos)) begin
			val_q <= right;
		end
	end

	// flag this cell for the group scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.mark_pos) begin
			hit_q <= at_pos;
		end else if (cmd.mark_val) begin
			hit_q <= (val_q == cmd.data) && (MY_IDX < count);
		end
	end

	assign value = val_q;
	assign hit   = hit_q;

endmodule

// ===== src/ple_group.sv =====
module ple_group (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic                                    shift,
	input  logic [ple_pkg::GRP_N-1:0]               hits,
	input  logic [ple_pkg::GRP_N-1:0][ple_pkg::DATA_W-1:0] vals,
	input  ple_pkg::grp_t                           nxt,
	output ple_pkg::grp_t                           slot
);
	import ple_pkg::*;

	grp_t slot_q;
	grp_t first;

	// pick the lowest flagged cell of the group
	always_comb begin
		first = '0;
		for (int k = GRP_N - 1; k >= 0; k--) begin
			if (hits[k]) begin
				first.any = 1'b1;
				first.idx = GRP_IW'(k);
				first.val = vals[k];
			end
		end
	end

	// load from the cells or advance toward slot zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= first;
		end else if (shift) begin
			slot_q <= nxt;
		end
	end

	assign slot = slot_q;

endmodule

// ===== src/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries, one command per word.
// Input channel s_*: one word holds func, position and data_value. Output
// channel m_*: one word holds status, removed_value, found_index and the
// list length after the command. Every input word yields one output word.
// Entries sit in a row of cells; insert shifts cells above the position up,
// remove shifts cells from the position down, and update writes one cell.
// Search and remove flag cells, the flags are folded into groups of 16
// cells, and the group slots shift toward slot zero one per cycle until
// the first flagged group reaches it.
// Insert, update and rejected commands go from accept to the done state;
// search and remove go through the group load state and then scan past the
// k groups ahead of the hit (k <= ceil(CAPACITY/16) - 1).
// s_tready is high only while no command is in flight, so one command runs
// at a time; s_tready rises again in the same cycle as m_tvalid, so the next
// word can be taken while the last result waits in the output register.
// The group scan chain sets the search and remove time.
// A finished word waits in the output register while m_tready is low, and
// the next command is taken meanwhile; it finishes once that word is gone.
// Reset empties the list at once; no clearing pass is needed.
module positional_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // func[1:0], position[8:2], data_value[40:9], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // status[1:0], removed_value[33:2], found_index[40:34],
	                              // list_length[47:41]
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam int G  = (CAPACITY + GRP_N - 1) / GRP_N;
	localparam int GW = (G > 1) ? $clog2(G) : 1;
	localparam int FW = GW + GRP_IW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DONE = 4'b0010,
		S_GRP  = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [1:0]       func_q;
	logic [PW-1:0]    pos_q;
	logic [1:0]       status_q;
	logic [GW-1:0]    scan_q;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;

	logic [1:0]        in_func;
	logic [PW-1:0]     in_pos;
	logic [DATA_W-1:0] in_val;
	logic [PW-1:0]     count_x;
	logic              accept;
	logic              full;
	logic              ins_ok;
	logic              idx_ok;
	logic              out_free;
	logic              scan_last;
	logic              scan_done;
	logic              finish;
	logic [FW-1:0]     gidx;
	logic [1:0]        res_status;
	logic [DATA_W-1:0] res_removed;
	logic [6:0]        res_found;
	cell_cmd_t         cmd;
	logic [PW-1:0]     cell_pos;

	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic              cell_hit [CAPACITY];
	logic [G*GRP_N-1:0]             hit_pad;
	logic [G*GRP_N-1:0][DATA_W-1:0] val_pad;
	grp_t              slot [G+1];

	// unpack the input word
	assign in_func = s_tdata[1:0];
	assign in_pos  = PW'(s_tdata[8:2]);
	assign in_val  = s_tdata[40:9];

	assign count_x  = PW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign accept   = s_tvalid && s_tready;
	assign ins_ok   = (in_pos <= count_x) && !full;
	assign idx_ok   = (in_pos < count_x);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// drive the cell row: edits at accept, the remove shift together with the snapshot
	always_comb begin
		cmd          = '0;
		cmd.data     = in_val;
		cmd.ins      = accept && (in_func == FN_INSERT) && ins_ok;
		cmd.upd      = accept && (in_func == FN_UPDATE) && idx_ok;
		cmd.mark_pos = accept && (in_func == FN_REMOVE) && idx_ok;
		cmd.mark_val = accept && (in_func == FN_SEARCH);
		cmd.rem      = (state_q == S_GRP) && (func_q == FN_REMOVE);
		cell_pos     = (state_q == S_GRP) ? pos_q : in_pos;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_val[i+1];
		end
		ple_cell #(
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.pos    (cell_pos),
			.count  (count_x),
			.left   (left_v),
			.right  (right_v),
			.value  (cell_val[i]),
			.hit    (cell_hit[i])
		);
	end

	// pad the row to whole groups
	for (genvar j = 0; j < G * GRP_N; j++) begin : g_pad
		if (j < CAPACITY) begin : g_live
			assign hit_pad[j] = cell_hit[j];
			assign val_pad[j] = cell_val[j];
		end else begin : g_void
			assign hit_pad[j] = 1'b0;
			assign val_pad[j] = '0;
		end
	end

	assign slot[G] = '0;

	for (genvar g = 0; g < G; g++) begin : g_grp
		ple_group u_group (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (state_q == S_GRP),
			.shift  ((state_q == S_SCAN) && !scan_done),
			.hits   (hit_pad[g*GRP_N +: GRP_N]),
			.vals   (val_pad[g*GRP_N +: GRP_N]),
			.nxt    (slot[g+1]),
			.slot   (slot[g])
		);
	end

	// form the result of the command in flight
	assign scan_last = (scan_q == GW'(G - 1));
	assign scan_done = slot[0].any || scan_last;
	assign gidx      = {scan_q, slot[0].idx};

	always_comb begin
		res_status  = status_q;
		res_removed = '0;
		res_found   = IDX_NONE;
		finish      = 1'b0;
		case (state_q)
			S_DONE: begin
				finish = out_free;
			end
			S_SCAN: begin
				finish = scan_done && out_free;
				if (func_q == FN_REMOVE) begin
					res_status  = ST_OK;
					res_removed = slot[0].val;
				end else if (slot[0].any) begin
					res_status = ST_OK;
					res_found  = 7'(gidx);
				end else begin
					res_status = ST_MISS;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// sequence one command at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			func_q   <= FN_INSERT;
			pos_q    <= '0;
			status_q <= ST_OK;
			scan_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= in_func;
						pos_q    <= in_pos;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						case (in_func)
							FN_INSERT: begin
								if (in_pos > count_x) begin
									status_q <= ST_RANGE;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							FN_REMOVE: begin
								if (idx_ok) begin
									state_q <= S_GRP;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							FN_SEARCH: begin
								state_q <= S_GRP;
							end
							default: begin
								if (!idx_ok) begin
									status_q <= ST_RANGE;
								end
							end
						endcase
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_GRP: begin
					scan_q  <= '0;
					state_q <= S_SCAN;
					if (func_q == FN_REMOVE) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_SCAN: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (!scan_done) begin
						scan_q <= scan_q + GW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {7'(count_q), res_found, res_removed, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length beyond capacity");

	// a remove in range always finds its flagged cell by the last group
	a_remove_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && func_q == FN_REMOVE && scan_last) |-> slot[0].any)
		else $error("remove scan ran out without its entry");

	// length only changes at accept or at the remove snapshot
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE || state_q == S_SCAN) |=> $stable(count_q))
		else $error("list length moved while finishing");

endmodule
